// ===== hdl/spq_pkg.sv =====
package spq_pkg;

	// command codes on the cmd field
	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_POP  = 1'b1;

	// item_out for a failed pop and for every push
	localparam logic [7:0] NO_ITEM = 8'hFF;

	// controller -> datapath
	typedef struct packed {
		logic latch;        // capture the input transaction
		logic do_read;      // registered read of link/value memories
		logic set_fail;     // result: failure
		logic push_commit;  // link in the new node
		logic pop_commit;   // unlink head, recycle node
		logic load_out;     // move result into the output register
	} ctl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic fail;         // bad level, pool full or queue empty
		logic is_pop;
		logic out_free;     // output register empty or being taken
	} dp_status_t;

endpackage

// ===== hdl/spq_ctrl.sv =====
module spq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  spq_pkg::dp_status_t status,
	output spq_pkg::ctl_cmd_t   ctl
);
	import spq_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CHECK = 2'd1;
	localparam logic [1:0] ST_EXEC  = 2'd2;
	localparam logic [1:0] ST_RESP  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nxt;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_nxt = state_q;
		ctl       = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					ctl.latch = 1'b1;
					state_nxt = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (status.fail) begin
					ctl.set_fail = 1'b1;
					state_nxt    = ST_RESP;
				end else begin
					ctl.do_read = 1'b1;
					state_nxt   = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (status.is_pop) begin
					ctl.pop_commit = 1'b1;
				end else begin
					ctl.push_commit = 1'b1;
				end
				state_nxt = ST_RESP;
			end
			ST_RESP: begin
				if (status.out_free) begin
					ctl.load_out = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// ===== hdl/spq_datapath.sv =====
module spq_datapath #(
	parameter int POOL_DEPTH = 32,
	parameter int LEVELS     = 3
) (
	input  logic                clk,
	input  logic                arst_n,
	input  spq_pkg::ctl_cmd_t   ctl,
	output spq_pkg::dp_status_t status,
	input  logic                cmd,
	input  logic [1:0]          level,
	input  logic [7:0]          item_in,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                success,
	output logic [7:0]          item_out
);
	import spq_pkg::*;

	localparam int NODE_W = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
	localparam int LINK_W = $clog2(POOL_DEPTH + 1);
	localparam int LV_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(POOL_DEPTH);

	// captured transaction
	logic        cmd_q;
	logic [1:0]  level_q;
	logic [7:0]  item_q;

	// list pointers; bump_q hands out nodes never used since reset
	logic [LINK_W-1:0] free_head_q;
	logic [LINK_W-1:0] bump_q;
	logic [LINK_W-1:0] head_q [LEVELS];
	logic [LINK_W-1:0] tail_q [LEVELS];

	// node memories
	logic [7:0]        node_value [POOL_DEPTH];
	logic [LINK_W-1:0] node_link  [POOL_DEPTH];
	logic [7:0]        value_rd_q;
	logic [LINK_W-1:0] link_rd_q;

	// result and output registers
	logic       res_success_q;
	logic [7:0] res_item_q;
	logic       out_valid_q;
	logic       success_q;
	logic [7:0] item_out_q;

	logic [LV_W-1:0]   lv_idx;
	logic              lv_ok;
	logic [LINK_W-1:0] head_sel;
	logic [LINK_W-1:0] tail_sel;
	logic              head_empty;
	logic              recycled;
	logic              pool_full;
	logic [NODE_W-1:0] new_node;
	logic [NODE_W-1:0] rd_addr;
	logic              link_we;
	logic [NODE_W-1:0] link_wa;
	logic [LINK_W-1:0] link_wd;
	logic [LINK_W-1:0] head_next;
	logic              last_node;

	assign lv_idx     = LV_W'(level_q);
	assign lv_ok      = (32'(level_q) < LEVELS);
	assign head_sel   = head_q[lv_idx];
	assign tail_sel   = tail_q[lv_idx];
	assign head_empty = (head_sel == LINK_NULL);
	assign recycled   = (free_head_q != LINK_NULL);
	assign pool_full  = !recycled && (bump_q == LINK_W'(POOL_DEPTH));
	assign new_node   = recycled ? free_head_q[NODE_W-1:0] : bump_q[NODE_W-1:0];
	assign rd_addr    = (cmd_q == CMD_POP) ? head_sel[NODE_W-1:0] : free_head_q[NODE_W-1:0];
	// the tail node's link is never trusted: head == tail marks a single entry
	assign last_node  = (head_sel == tail_sel);
	assign head_next  = last_node ? LINK_NULL : link_rd_q;

	assign status.fail     = !lv_ok || ((cmd_q == CMD_POP) ? head_empty : pool_full);
	assign status.is_pop   = (cmd_q == CMD_POP);
	assign status.out_free = !out_valid_q || !out_stall;

	always_comb begin
		link_we = 1'b0;
		link_wa = tail_sel[NODE_W-1:0];
		link_wd = LINK_W'(new_node);
		if (ctl.push_commit && !head_empty) begin
			link_we = 1'b1;
		end else if (ctl.pop_commit) begin
			link_we = 1'b1;
			link_wa = head_sel[NODE_W-1:0];
			link_wd = free_head_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			cmd_q   <= cmd;
			level_q <= level;
			item_q  <= item_in;
		end
		if (ctl.do_read) begin
			value_rd_q <= node_value[rd_addr];
			link_rd_q  <= node_link[rd_addr];
		end
		if (ctl.push_commit) begin
			node_value[new_node] <= item_q;
		end
		if (link_we) begin
			node_link[link_wa] <= link_wd;
		end
		if (ctl.set_fail) begin
			res_success_q <= 1'b0;
			res_item_q    <= NO_ITEM;
		end else if (ctl.push_commit) begin
			res_success_q <= 1'b1;
			res_item_q    <= NO_ITEM;
		end else if (ctl.pop_commit) begin
			res_success_q <= 1'b1;
			res_item_q    <= value_rd_q;
		end
		if (ctl.load_out) begin
			success_q  <= res_success_q;
			item_out_q <= res_item_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q <= LINK_NULL;
			bump_q      <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < LEVELS; i++) begin
				head_q[i] <= LINK_NULL;
				tail_q[i] <= LINK_NULL;
			end
		end else begin
			if (ctl.push_commit) begin
				if (recycled) begin
					free_head_q <= link_rd_q;
				end else begin
					bump_q <= bump_q + 1'b1;
				end
				if (head_empty) begin
					head_q[lv_idx] <= LINK_W'(new_node);
				end
				tail_q[lv_idx] <= LINK_W'(new_node);
			end else if (ctl.pop_commit) begin
				head_q[lv_idx] <= head_next;
				if (last_node) begin
					tail_q[lv_idx] <= LINK_NULL;
				end
				free_head_q <= head_sel;
			end
			if (ctl.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign success   = success_q;
	assign item_out  = item_out_q;

endmodule

// ===== hdl/shared_pool_priority_queues.sv =====
// LEVELS FIFO queues, one per priority level, sharing a pool of POOL_DEPTH
// linked nodes. A push (cmd 0) appends item_in to the queue of its level and
// returns success 1, item_out 255; it fails when the pool is full or the level
// is not below LEVELS. A pop (cmd 1) returns the head item of its level with
// success 1, or success 0 and item_out 255 when that queue is empty or the
// level is invalid. Every input transaction yields exactly one output
// transaction, in order. One transaction is in work at a time: a successful
// push or pop goes from acceptance through check with registered read of the
// node link/value memories, commit and output load, a failed one through check
// and output load; the output load waits for the output register to free up,
// and the next input is taken the cycle after the output load. The next input
// is taken even while the previous result is still stalled in the output
// register.
// No clearing pass is needed after reset: never-used nodes are handed out by
// a fill counter, freed nodes through a free list.
module shared_pool_priority_queues #(
	parameter int POOL_DEPTH = 32,  // 2 to 254
	parameter int LEVELS     = 3    // 1 to 8; levels beyond 3 are unreachable
) (
	input  logic       clk,
	input  logic       arst_n,
	// input channel
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       cmd,
	input  logic [1:0] level,
	input  logic [7:0] item_in,
	// output channel
	output logic       out_valid,
	input  logic       out_stall,
	output logic       success,
	output logic [7:0] item_out
);
	import spq_pkg::*;

	ctl_cmd_t   ctl;
	dp_status_t status;

	// sequencer: idle -> check -> exec -> resp, or idle -> check -> resp on a failure
	spq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.ctl      (ctl)
	);

	// pointers, node memories, result and output registers
	spq_datapath #(
		.POOL_DEPTH (POOL_DEPTH),
		.LEVELS     (LEVELS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.status    (status),
		.cmd       (cmd),
		.level     (level),
		.item_in   (item_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.success   (success),
		.item_out  (item_out)
	);

endmodule

// ===== hdl/spq_checker.sv =====
module spq_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic       success,
	input logic [7:0] item_out
);

	// transactions accepted but not yet delivered
	logic [1:0] pend_q;
	logic       in_take;
	logic       out_take;

	assign in_take  = in_valid && !in_stall;
	assign out_take = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_take && !out_take) begin
			pend_q <= pend_q + 1'b1;
		end else if (out_take && !in_take) begin
			pend_q <= pend_q - 1'b1;
		end
	end

	// held result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(success) && $stable(item_out))
		else $error("stalled output changed");

	// one transaction in work: input closes right after acceptance
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> in_stall)
		else $error("input accepted while busy");

	// failures always carry the empty marker
	a_fail_item: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !success |-> item_out == 8'hFF)
		else $error("failed result with item");

	// no result without an accepted transaction, at most two outstanding
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid |-> pend_q != 2'd0) and (pend_q != 2'd3))
		else $error("result count mismatch");

endmodule

bind shared_pool_priority_queues spq_checker u_spq_checker (.*);

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

// Self-checking bench for the shared-pool priority queues.
// A directed table runs first, then randomized push/pop phases that fill the
// node pool, drain it and mix the two. Every accepted input transaction is
// run through a local copy of the queues and the pool. The predicted result
// is queued and checked in order against each output transaction.
module testbench;
	import spq_pkg::*;

	localparam int POOL       = 32;
	localparam int NUM_LEVELS = 3;
	localparam logic [1:0] LVL_INVALID = 2'd3;  // no queue behind this level
	localparam int RANDOM_ITEMS = 1550;
	localparam int HOLD_AT      = 600;   // accepted count that starts the long hold-off
	localparam int HOLD_CYCLES  = 250;
	localparam int QUIET_LIMIT  = 2000;  // cycles with no transaction before giving up
	localparam int MAX_REPORTS  = 200;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic       cmd = CMD_PUSH;
	logic [1:0] level = 2'd0;
	logic [7:0] item_in = 8'd0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       success;
	logic [7:0] item_out;

	shared_pool_priority_queues #(
		.POOL_DEPTH(POOL),
		.LEVELS(NUM_LEVELS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.level(level),
		.item_in(item_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.success(success),
		.item_out(item_out)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Local copy of the queues and node pool.
	// Node indexes are 6 bits; all ones marks an empty link.
	// ------------------------------------------------------------------
	typedef logic [5:0] node_t;
	localparam node_t NIL = 6'h3F;

	logic [7:0] pool_value [POOL];
	node_t      pool_link [POOL];
	node_t      lvl_head [NUM_LEVELS];
	node_t      lvl_tail [NUM_LEVELS];
	node_t      free_top;

	function automatic bit is_node(node_t n);
		return int'(n) < POOL;
	endfunction

	// Free list starts as 0 -> 1 -> ... -> POOL-1, all queues empty.
	function automatic void pool_clear();
		for (int i = 0; i < POOL; i++) begin
			pool_value[i] = 8'd0;
			pool_link[i] = (i + 1 < POOL) ? node_t'(i + 1) : NIL;
		end
		for (int i = 0; i < NUM_LEVELS; i++) begin
			lvl_head[i] = NIL;
			lvl_tail[i] = NIL;
		end
		free_top = 6'd0;
	endfunction

	// Apply one push or pop to the local queues, return the result it gives.
	function automatic void queue_apply(input logic c, input logic [1:0] l,
			input logic [7:0] d, output logic ok, output logic [7:0] val);
		node_t n;
		ok = 1'b0;
		val = NO_ITEM;
		if (int'(l) >= NUM_LEVELS)
			return;
		if (c == CMD_PUSH) begin
			if (!is_node(free_top))
				return;  // pool exhausted
			n = free_top;
			free_top = pool_link[n];
			pool_value[n] = d;
			pool_link[n] = NIL;
			if (!is_node(lvl_head[l]))
				lvl_head[l] = n;
			else
				pool_link[lvl_tail[l]] = n;
			lvl_tail[l] = n;
			ok = 1'b1;
		end else begin
			n = lvl_head[l];
			if (!is_node(n))
				return;  // queue empty
			ok = 1'b1;
			val = pool_value[n];
			lvl_head[l] = pool_link[n];
			if (!is_node(lvl_head[l])) begin
				lvl_head[l] = NIL;
				lvl_tail[l] = NIL;
			end
			pool_link[n] = free_top;
			free_top = n;
		end
	endfunction

	// ------------------------------------------------------------------
	// Expected results, oldest first.
	// ------------------------------------------------------------------
	typedef struct packed {
		logic       ok;
		logic [7:0] val;
	} result_t;

	result_t results_due[$];
	int n_errors = 0;
	int n_accepted = 0;

	// ------------------------------------------------------------------
	// Directed rows. Where "typed" is set, the result is written out here;
	// the local model still sees the transaction so its state stays in step.
	// ------------------------------------------------------------------
	typedef struct packed {
		logic       c;
		logic [1:0] l;
		logic [7:0] d;
		logic       typed;
		logic       ok;
		logic [7:0] val;
	} dir_row_t;

	localparam int DIR_ROWS = 24;
	dir_row_t dir_tab [DIR_ROWS] = '{
		// pops on empty queues right after reset, including the bad level
		'{CMD_POP,  2'd0,        8'h00, 1'b1, 1'b0, NO_ITEM},
		'{CMD_POP,  2'd1,        8'hFF, 1'b1, 1'b0, NO_ITEM},
		'{CMD_POP,  2'd2,        8'h00, 1'b1, 1'b0, NO_ITEM},
		'{CMD_POP,  LVL_INVALID, 8'h00, 1'b1, 1'b0, NO_ITEM},
		// push to the bad level is refused
		'{CMD_PUSH, LVL_INVALID, 8'hA5, 1'b1, 1'b0, NO_ITEM},
		// value extremes, 255 stored as data
		'{CMD_PUSH, 2'd0,        8'hFF, 1'b1, 1'b1, NO_ITEM},
		'{CMD_PUSH, 2'd0,        8'h00, 1'b1, 1'b1, NO_ITEM},
		'{CMD_PUSH, 2'd1,        8'h5A, 1'b1, 1'b1, NO_ITEM},
		'{CMD_PUSH, 2'd2,        8'h80, 1'b1, 1'b1, NO_ITEM},
		'{CMD_PUSH, 2'd2,        8'h01, 1'b1, 1'b1, NO_ITEM},
		'{CMD_PUSH, LVL_INVALID, 8'h00, 1'b1, 1'b0, NO_ITEM},
		// bad-level pop while other queues hold data
		'{CMD_POP,  LVL_INVALID, 8'hFF, 1'b1, 1'b0, NO_ITEM},
		// a stored 255 comes back with success set
		'{CMD_POP,  2'd0,        8'h00, 1'b1, 1'b1, 8'hFF},
		'{CMD_POP,  2'd0,        8'h00, 1'b1, 1'b1, 8'h00},
		'{CMD_POP,  2'd0,        8'h00, 1'b1, 1'b0, NO_ITEM},
		'{CMD_POP,  2'd2,        8'h00, 1'b1, 1'b1, 8'h80},
		// recycled nodes from here on: left to the model, but for the level-1 pop of 8'h5A
		'{CMD_PUSH, 2'd1,        8'h7F, 1'b0, 1'b0, NO_ITEM},
		'{CMD_POP,  2'd1,        8'h00, 1'b1, 1'b1, 8'h5A},
		'{CMD_POP,  2'd1,        8'h00, 1'b0, 1'b0, NO_ITEM},
		'{CMD_POP,  2'd2,        8'h00, 1'b0, 1'b0, NO_ITEM},
		'{CMD_POP,  2'd1,        8'h00, 1'b0, 1'b0, NO_ITEM},
		'{CMD_PUSH, 2'd0,        8'hAA, 1'b0, 1'b0, NO_ITEM},
		'{CMD_PUSH, 2'd0,        8'h55, 1'b0, 1'b0, NO_ITEM},
		'{CMD_POP,  2'd0,        8'h00, 1'b0, 1'b0, NO_ITEM}
	};

	// ------------------------------------------------------------------
	// Sender: bursts of back-to-back transactions with idle gaps between.
	// valid is only dropped when a gap follows, so it never gets two
	// assignments in one step.
	// ------------------------------------------------------------------
	int burst_left = 0;

	task automatic offer(input logic c, input logic [1:0] l, input logic [7:0] d,
			input logic typed, input logic eok, input logic [7:0] eval);
		result_t r;
		logic    pok;
		logic [7:0] pval;
		int      gap;
		cmd <= c;
		level <= l;
		item_in <= d;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		queue_apply(c, l, d, pok, pval);
		r.ok = typed ? eok : pok;
		r.val = typed ? eval : pval;
		results_due.push_back(r);
		n_accepted++;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			// about a third of the bursts run straight into the next one
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Main flow: reset, directed table, random phases, drain, verdict.
	// ------------------------------------------------------------------
	initial begin : main_flow
		int         phase_left;
		int         push_pct;
		logic       c;
		logic [1:0] l;
		logic [7:0] d;
		pool_clear();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++)
			offer(dir_tab[i].c, dir_tab[i].l, dir_tab[i].d,
				dir_tab[i].typed, dir_tab[i].ok, dir_tab[i].val);

		// Random phases: fill-heavy runs overflow the pool, drain-heavy runs
		// empty the queues, mixed runs churn the free list.
		phase_left = 0;
		push_pct = 50;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (phase_left == 0) begin
				phase_left = $urandom_range(20, 80);
				case ($urandom_range(0, 2))
					0: push_pct = 85;
					1: push_pct = 15;
					default: push_pct = 50;
				endcase
			end
			phase_left--;
			c = ($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP;
			l = ($urandom_range(0, 19) == 0) ? LVL_INVALID : 2'($urandom_range(0, 2));
			case ($urandom_range(0, 9))
				0: d = 8'h00;
				1: d = 8'hFF;
				default: d = 8'($urandom_range(0, 255));
			endcase
			offer(c, l, d, 1'b0, 1'b0, NO_ITEM);
		end
		in_valid <= 1'b0;

		// drain: the watchdog covers a result that never shows up
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (n_errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// ------------------------------------------------------------------
	// Receiver: stall pattern changes by phase; one long hold-off lets the
	// block back up into its input while the sender keeps offering.
	// ------------------------------------------------------------------
	initial begin : rx_side
		int hold_left;
		bit hold_done;
		int phase_left;
		int stall_mode;
		int cyc;
		hold_left = 0;
		hold_done = 1'b0;
		phase_left = 0;
		stall_mode = 0;
		cyc = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			cyc++;
			if (!hold_done && n_accepted >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				if (phase_left == 0) begin
					stall_mode = $urandom_range(0, 3);
					phase_left = $urandom_range(50, 300);
				end
				phase_left--;
				case (stall_mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					2: out_stall <= ($urandom_range(0, 9) < 6);
					default: out_stall <= ((cyc % 7) < 3);
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// Result checker: compares each output transaction with the oldest
	// prediction. Values read right at the edge are the pre-edge ones.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (results_due.size() == 0) begin
				n_errors++;
				if (n_errors <= MAX_REPORTS)
					$display("%0t: unexpected result success %0b item_out %0d",
						$time, success, item_out);
			end else begin
				want = results_due.pop_front();
				if (success !== want.ok) begin
					n_errors++;
					if (n_errors <= MAX_REPORTS)
						$display("%0t: success expected %0b got %0b",
							$time, want.ok, success);
				end
				if (item_out !== want.val) begin
					n_errors++;
					if (n_errors <= MAX_REPORTS)
						$display("%0t: item_out expected %0d got %0d",
							$time, want.val, item_out);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: too long without any transaction on either side.
	// ------------------------------------------------------------------
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no transaction for %0d cycles, %0d results outstanding",
				$time, QUIET_LIMIT, results_due.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

endmodule
